// ----- src/sha1_pkg.sv -----
// ============================================================================
// sha1_pkg
// Shared types, constants and round functions for the SHA-1 message hasher.
// ============================================================================
package sha1_pkg;

    localparam int WORD_W    = 32;
    localparam int BLOCK_W   = 512;
    localparam int ROUND_W   = 7;
    localparam int POS_W     = 6;
    localparam int COUNT_W   = 61;
    localparam int LEN_W     = 64;
    localparam int WSEL_W    = 3;
    localparam int NUM_WORDS = 5;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [POS_W-1:0]   LAST_POS   = 6'd63;
    localparam logic [WSEL_W-1:0]  LAST_WORD  = 3'd4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Initial chaining value
    localparam logic [WORD_W-1:0] IV0 = 32'h67452301;
    localparam logic [WORD_W-1:0] IV1 = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV2 = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV3 = 32'h10325476;
    localparam logic [WORD_W-1:0] IV4 = 32'hc3d2e1f0;

    // Round constants
    localparam logic [WORD_W-1:0] K0 = 32'h5a827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ed9eba1;
    localparam logic [WORD_W-1:0] K2 = 32'h8f1bbcdc;
    localparam logic [WORD_W-1:0] K3 = 32'hca62c1d6;

    // Source of the byte shifted into the block buffer
    typedef enum logic [1:0] {
        BSEL_DATA  = 2'd0,
        BSEL_PAD   = 2'd1,
        BSEL_ZERO  = 2'd2,
        BSEL_LEN   = 2'd3
    } byte_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic               shift_byte;
        byte_sel_t          byte_sel;
        logic               count_en;
        logic               load_len;
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round;
        logic               add_en;
        logic               init_en;
        logic [WSEL_W-1:0]  word_sel;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [POS_W-1:0] pos;
    } dp_stat_t;

    function automatic logic [WORD_W-1:0] sha1_k(input logic [ROUND_W-1:0] rnd);
        logic [WORD_W-1:0] k;
        begin
            if (rnd < 7'd20)
                k = K0;
            else if (rnd < 7'd40)
                k = K1;
            else if (rnd < 7'd60)
                k = K2;
            else
                k = K3;
            return k;
        end
    endfunction

    function automatic logic [WORD_W-1:0] sha1_f(input logic [ROUND_W-1:0] rnd,
                                                 input logic [WORD_W-1:0]  b,
                                                 input logic [WORD_W-1:0]  c,
                                                 input logic [WORD_W-1:0]  d);
        logic [WORD_W-1:0] f;
        begin
            if (rnd < 7'd20)
                f = (b & c) | (~b & d);
            else if (rnd < 7'd40)
                f = b ^ c ^ d;
            else if (rnd < 7'd60)
                f = (b & c) | (b & d) | (c & d);
            else
                f = b ^ c ^ d;
            return f;
        end
    endfunction

endpackage

// ----- src/sha1_datapath.sv -----
// ============================================================================
// sha1_datapath
// Block buffer / message schedule window, round unit, chaining value,
// byte count and length register.
// ============================================================================
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [7:0]          data_byte,
    output logic [WORD_W-1:0]   digest_word
);

    // 512-bit buffer; oldest word in the top bits, doubles as schedule window
    logic [BLOCK_W-1:0] buf_reg;
    logic [BLOCK_W-1:0] buf_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic [POS_W-1:0]   pos_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [WORD_W-1:0]  chain_reg [NUM_WORDS];
    logic [WORD_W-1:0]  a_reg, b_reg, c_reg, d_reg, e_reg;

    logic [7:0]         byte_in;
    logic [WORD_W-1:0]  w0, w2, w8, w13, w_mix, w_new;
    logic [WORD_W-1:0]  temp;

    // Byte source select
    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_DATA: byte_in = data_byte;
            BSEL_PAD:  byte_in = PAD_BYTE;
            BSEL_ZERO: byte_in = 8'h00;
            BSEL_LEN:  byte_in = len_reg[LEN_W-1 -: 8];
            default:   byte_in = 8'h00;
        endcase
    end

    // Schedule taps: w[t], w[t+2], w[t+8], w[t+13]
    assign w0    = buf_reg[BLOCK_W-1 -: WORD_W];
    assign w2    = buf_reg[BLOCK_W-1-2*WORD_W -: WORD_W];
    assign w8    = buf_reg[BLOCK_W-1-8*WORD_W -: WORD_W];
    assign w13   = buf_reg[BLOCK_W-1-13*WORD_W -: WORD_W];
    assign w_mix = w13 ^ w8 ^ w2 ^ w0;
    assign w_new = {w_mix[WORD_W-2:0], w_mix[WORD_W-1]};

    // One round
    assign temp = {a_reg[WORD_W-6:0], a_reg[WORD_W-1 -: 5]}
                + sha1_f(cmd.round, b_reg, c_reg, d_reg)
                + e_reg + w0 + sha1_k(cmd.round);

    // Buffer and length next values
    always_comb
    begin
        buf_next = buf_reg;
        if (cmd.shift_byte)
            buf_next = {buf_reg[BLOCK_W-9:0], byte_in};
        else if (cmd.round_en)
            buf_next = {buf_reg[BLOCK_W-WORD_W-1:0], w_new};

        len_next = len_reg;
        if (cmd.load_len)
            len_next = {count_reg, 3'b000};
        else if (cmd.shift_byte && cmd.byte_sel == BSEL_LEN)
            len_next = {len_reg[LEN_W-9:0], 8'h00};
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        len_reg <= len_next;
        if (cmd.load_work)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (cmd.round_en)
        begin
            a_reg <= temp;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[WORD_W-1:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    // Chaining value, byte count and buffer fill position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV0;
            chain_reg[1] <= IV1;
            chain_reg[2] <= IV2;
            chain_reg[3] <= IV3;
            chain_reg[4] <= IV4;
            count_reg    <= '0;
            pos_reg      <= '0;
        end
        else
        begin
            if (cmd.init_en)
            begin
                chain_reg[0] <= IV0;
                chain_reg[1] <= IV1;
                chain_reg[2] <= IV2;
                chain_reg[3] <= IV3;
                chain_reg[4] <= IV4;
                count_reg    <= '0;
            end
            else
            begin
                if (cmd.add_en)
                begin
                    chain_reg[0] <= chain_reg[0] + a_reg;
                    chain_reg[1] <= chain_reg[1] + b_reg;
                    chain_reg[2] <= chain_reg[2] + c_reg;
                    chain_reg[3] <= chain_reg[3] + d_reg;
                    chain_reg[4] <= chain_reg[4] + e_reg;
                end
                if (cmd.count_en)
                    count_reg <= count_reg + 1'b1;
            end
            if (cmd.shift_byte)
                pos_reg <= pos_reg + 1'b1;
        end
    end

    // Digest word select
    always_comb
    begin
        unique case (cmd.word_sel)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign stat.pos = pos_reg;

endmodule

// ----- src/sha1_ctrl.sv -----
// ============================================================================
// sha1_ctrl
// Sequencer: byte intake, padding, 80-round compression and digest output.
// ============================================================================
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              byte_valid,
    input  logic              end_msg,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WSEL_W-1:0] word_index,
    output logic              last_word,
    output dp_cmd_t           cmd,
    input  dp_stat_t          stat
);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_PAD_ONE  = 6'b000010,
        ST_PAD_FILL = 6'b000100,
        ST_ROUND    = 6'b001000,
        ST_ADD      = 6'b010000,
        ST_OUT      = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic [WSEL_W-1:0]  word_reg, word_next;
    logic               extra_reg, extra_next;
    logic               pos_last;
    logic               pos_tail;

    assign pos_last = (stat.pos == LAST_POS);
    assign pos_tail = (stat.pos[POS_W-1 -: 3] == 3'b111);

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        word_next  = word_reg;
        extra_next = extra_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;

        cmd            = '0;
        cmd.byte_sel   = BSEL_DATA;
        cmd.round      = round_reg;
        cmd.word_sel   = word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (byte_valid)
                    begin
                        cmd.shift_byte = 1'b1;
                        cmd.count_en   = 1'b1;
                    end
                    if (byte_valid && pos_last)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        state_next    = ST_ROUND;
                        ret_next      = end_msg ? ST_PAD_ONE : ST_IDLE;
                    end
                    else if (end_msg)
                        state_next = ST_PAD_ONE;
                end
            end

            ST_PAD_ONE:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_PAD;
                cmd.load_len   = 1'b1;
                if (pos_last)
                begin
                    // marker fills the block: zeros and length go in a new one
                    extra_next    = 1'b0;
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    ret_next      = ST_PAD_FILL;
                    state_next    = ST_ROUND;
                end
                else
                begin
                    extra_next = pos_tail;
                    state_next = ST_PAD_FILL;
                end
            end

            ST_PAD_FILL:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = (pos_tail && !extra_reg) ? BSEL_LEN : BSEL_ZERO;
                if (pos_last)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    ret_next      = extra_reg ? ST_PAD_FILL : ST_OUT;
                    extra_next    = 1'b0;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                round_next   = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                cmd.add_en = 1'b1;
                word_next  = '0;
                state_next = ret_reg;
            end

            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (word_reg == LAST_WORD)
                    begin
                        cmd.init_en = 1'b1;
                        word_next   = '0;
                        state_next  = ST_IDLE;
                    end
                    else
                        word_next = word_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign word_index = word_reg;
    assign last_word  = (word_reg == LAST_WORD);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
            word_reg  <= '0;
            extra_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            word_reg  <= word_next;
            extra_reg <= extra_next;
        end
    end

endmodule

// ----- src/sha1_message_hasher_top.sv -----
// ============================================================================
// sha1_message_hasher_top
// SHA-1 hasher fed one message byte per request; emits the 160-bit digest
// as five 32-bit words at end of message.
//
// Channel  Dir  tdata               tuser           tlast
// s_*      in   data_byte[7:0]      byte_valid      end_of_message
// m_*      out  digest_word[31:0]   word_index[2:0] last_word
//
// A message byte is shifted in when accepted. The 64th byte of a block starts
// the shared round unit: 80 rounds plus one chaining add, with s_tready low.
// End of message shifts the pad bytes in one per cycle outside compressions
// (at most 64, or 72 when the length needs an extra block), runs one or two
// compressions, then offers the five digest words.
// rst_n is asynchronous and loads the initial chaining value.
// ============================================================================
module sha1_message_hasher_top
    import sha1_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] byte_valid
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [31:0] digest_word
    output logic [2:0]   m_tuser,   // [2:0] word_index
    output logic         m_tlast
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    sha1_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .byte_valid (s_tuser),
        .end_msg    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .word_index (m_tuser),
        .last_word  (m_tlast),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Datapath
    sha1_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .data_byte   (s_tdata),
        .digest_word (m_tdata)
    );

endmodule

// ----- verif/sha1_digest_checker.sv -----
// ============================================================================
// sha1_digest_checker
// Watches both stream channels of the SHA-1 message hasher. Every accepted
// request is fed to a local SHA-1 predictor; every accepted digest word is
// compared field by field with the oldest predicted word.
// ============================================================================
module sha1_digest_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] byte_valid
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [31:0]  m_tdata,   // [31:0] digest_word
    input  logic [2:0]   m_tuser,   // [2:0] word_index
    input  logic         m_tlast,
    output int           fail_count,
    output int           outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGEST_WORDS = 5;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    // Predictor state
    logic [31:0]  hash_h [DIGEST_WORDS];
    logic [7:0]   block_buf [64];
    logic [60:0]  bytes_taken;

    digest_beat_t expected_digest[$];
    int           mismatches = 0;

    // Back to the initial chaining value, empty message
    function automatic void restart_hash();
        hash_h[0]   = 32'h67452301;
        hash_h[1]   = 32'hefcdab89;
        hash_h[2]   = 32'h98badcfe;
        hash_h[3]   = 32'h10325476;
        hash_h[4]   = 32'hc3d2e1f0;
        bytes_taken = '0;
    endfunction

    // One 80-round compression of block_buf into hash_h
    function automatic void compress_buffer();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t, x;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (i = 16; i < 80; i++)
        begin
            x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
        end
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (i = 0; i < 80; i++)
        begin
            if (i < 20)
            begin
                f = (b & c) | (~b & d);
                k = 32'h5a827999;
            end
            else if (i < 40)
            begin
                f = b ^ c ^ d;
                k = 32'h6ed9eba1;
            end
            else if (i < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = 32'h8f1bbcdc;
            end
            else
            begin
                f = b ^ c ^ d;
                k = 32'hca62c1d6;
            end
            t = {a[26:0], a[31:27]} + f + e + w[i] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    // Pad, append the bit length, compress, queue the digest words
    function automatic void finish_digest();
        int           used;
        logic [63:0]  bit_len;
        digest_beat_t beat;
        int           i;
        used    = int'(bytes_taken[5:0]);
        bit_len = {bytes_taken, 3'b000};
        block_buf[used] = 8'h80;
        used++;
        if (used > 56)
        begin
            for (i = used; i < 64; i++)
                block_buf[i] = 8'h00;
            compress_buffer();
            used = 0;
        end
        for (i = used; i < 56; i++)
            block_buf[i] = 8'h00;
        for (i = 0; i < 8; i++)
            block_buf[56+i] = bit_len[63-8*i -: 8];
        compress_buffer();
        for (i = 0; i < DIGEST_WORDS; i++)
        begin
            beat.word  = hash_h[i];
            beat.index = 3'(i);
            beat.last  = (i == DIGEST_WORDS - 1);
            expected_digest.push_back(beat);
        end
        restart_hash();
    endfunction

    // Take one request into the predictor
    function automatic void absorb_request(input logic [7:0] data_byte,
                                           input logic byte_valid,
                                           input logic end_of_message);
        if (byte_valid)
        begin
            block_buf[bytes_taken[5:0]] = data_byte;
            bytes_taken = bytes_taken + 61'd1;
            if (bytes_taken[5:0] == 6'd0)
                compress_buffer();
        end
        if (end_of_message)
            finish_digest();
    endfunction

    // Compare one accepted digest word with the oldest prediction
    function automatic void check_digest_word();
        digest_beat_t want;
        if (expected_digest.size() == 0)
        begin
            $display("%0t: unexpected digest word: expected none, got %h idx %0d last %b",
                     $realtime, m_tdata, m_tuser, m_tlast);
            mismatches++;
            return;
        end
        want = expected_digest.pop_front();
        if (m_tdata !== want.word)
        begin
            $display("%0t: digest_word mismatch: expected %h, got %h",
                     $realtime, want.word, m_tdata);
            mismatches++;
        end
        if (m_tuser !== want.index)
        begin
            $display("%0t: word_index mismatch: expected %0d, got %0d",
                     $realtime, want.index, m_tuser);
            mismatches++;
        end
        if (m_tlast !== want.last)
        begin
            $display("%0t: last_word mismatch: expected %b, got %b",
                     $realtime, want.last, m_tlast);
            mismatches++;
        end
    endfunction

    // Channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_hash();
            expected_digest.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_digest_word();
            if (s_tvalid && s_tready)
                absorb_request(s_tdata, s_tuser, s_tlast);
            outstanding <= expected_digest.size();
        end
        fail_count <= mismatches;
    end

endmodule

// ----- verif/tb.sv -----
// ============================================================================
// tb
// Stimulus and verdict for the SHA-1 message hasher. Sends a few directed
// messages (empty message, empty tail, ignored requests, byte extremes),
// then random messages sized around the padding and block boundaries,
// with random gaps on both channels. Checking is done by sha1_digest_checker.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TARGET_REQUESTS = 480;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 400;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // [7:0] data_byte
    logic         s_tuser;   // [0] byte_valid
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;   // [31:0] digest_word
    logic [2:0]   m_tuser;   // [2:0] word_index
    logic         m_tlast;

    int fail_count;
    int outstanding;

    int requests_sent = 0;
    int tx_calm       = 0;
    int rx_stall      = 0;
    int rx_calm       = 0;
    int idle_cycles   = 0;

    sha1_message_hasher_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sha1_digest_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Message byte, biased toward the extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        else if (r < 16)
            return 8'hff;
        return 8'($urandom_range(0, 255));
    endfunction

    // Downstream back-pressure
    always @(posedge clk)
    begin
        if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (rx_calm > 0)
                rx_calm <= rx_calm - 1;
            else if ($urandom_range(0, 99) < 30)
                rx_stall <= gap_len();
            else if ($urandom_range(0, 99) == 0)
                rx_calm <= $urandom_range(100, 300);
        end
    end

    // Watchdog on cycles with no request accepted on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Offer one request after an optional gap; returns once accepted
    task automatic push_request(input logic [7:0] data_byte, input logic byte_valid,
                                input logic end_of_message);
        int gap;
        gap = 0;
        if (tx_calm > 0)
            tx_calm--;
        else if ($urandom_range(0, 99) < 35)
            gap = gap_len();
        else if ($urandom_range(0, 199) == 0)
            tx_calm = $urandom_range(80, 200);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_byte;
        s_tuser  <= byte_valid;
        s_tlast  <= end_of_message;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (byte_valid || end_of_message)
            requests_sent++;
    endtask

    // Hold the sender until every predicted digest word has arrived
    task automatic wait_for_digests();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // One message with random content; end marked on the last byte or on
    // a separate empty tail request; ignored requests sprinkled in
    task automatic send_message(input int len, input bit split_tail);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < 4)
                push_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_request(pick_byte(), 1'b1, (i == len - 1) && !split_tail);
        end
        if (len == 0 || split_tail)
            push_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Message length spread over the padding and block boundaries
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 20);
        else if (r < 75)
            return $urandom_range(52, 68);
        else if (r < 88)
            return $urandom_range(116, 132);
        return $urandom_range(0, 3);
    endfunction

    initial
    begin
        int msg_count;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: ignored request, empty message, "abc"
        push_request(8'h5a, 1'b0, 1'b0);
        push_request(8'hff, 1'b0, 1'b1);
        push_request(8'h61, 1'b1, 1'b0);
        push_request(8'h62, 1'b1, 1'b0);
        push_request(8'h63, 1'b1, 1'b1);
        // byte extremes, ignored request mid-message, empty tail
        push_request(8'h00, 1'b1, 1'b0);
        push_request(8'hff, 1'b0, 1'b0);
        push_request(8'hff, 1'b1, 1'b0);
        push_request(8'h00, 1'b0, 1'b1);
        // single-byte messages at the extremes, back to back
        push_request(8'h80, 1'b1, 1'b1);
        push_request(8'hff, 1'b1, 1'b1);
        push_request(8'h00, 1'b1, 1'b1);
        wait_for_digests();

        // Random messages
        msg_count = 0;
        while (requests_sent < TARGET_REQUESTS)
        begin
            send_message(pick_length(), $urandom_range(0, 99) < 30);
            msg_count++;
            if (msg_count % 6 == 0)
                wait_for_digests();
        end

        // Drain and verdict
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
